@@ rtl/max_subarray_segment_tree_macros.svh @@
// assertion macros used by the checker file
`ifndef MAX_SUBARRAY_SEGMENT_TREE_MACROS_SVH
`define MAX_SUBARRAY_SEGMENT_TREE_MACROS_SVH

// same-cycle implication, held off during reset
`define MSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mss checker: same-cycle property failed");

// next-cycle implication, held off during reset
`define MSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mss checker: next-cycle property failed");

`endif

@@ rtl/mss_pkg.sv @@
// shared constants for the maximum-subarray segment tree
package mss_pkg;

    // field widths of the transaction ports
    localparam int IDX_W      = 10;
    localparam int VAL_W      = 32;
    localparam int ANS_W      = 42;
    localparam int PFX_W      = 41;

    // value width held in the tree
    localparam int VALUE_BITS = 32;

    // default number of slots
    localparam int SLOTS_DEFAULT = 1024;

    // func codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

endpackage

@@ rtl/max_subarray_segment_tree.sv @@
// Maximum-subarray segment tree: one node store, a shared combine unit and a sequencer.
// After reset the block clears its 2*SLOTS node entries, one per cycle, holding in_stall high
// until the last entry is cleared. A write stores the leaf, then for each tree level reads the
// sibling node (S_UP_RD) and combines it and writes back the parent (S_UP_WR), up to the root. A
// query walks the tree bottom up, taking up to two node reads per level one after another through
// the single read port, a level step in S_Q_STEP and a final merge in S_Q_FIN. A rejected range
// goes straight to S_Q_FIN; the result register is loaded there once the output register is free.
// One transaction is in work at a time; a finished result sits in the output register while the
// next transaction is taken.
module max_subarray_segment_tree
    import mss_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    func,
    input  logic [IDX_W-1:0]        slot_index,
    input  logic signed [VAL_W-1:0] slot_value,
    input  logic [IDX_W-1:0]        range_first,
    input  logic [IDX_W-1:0]        range_last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [ANS_W-1:0] best_answer,
    output logic signed [ANS_W-1:0] range_sum,
    output logic [PFX_W-1:0]        best_prefix,
    output logic [PFX_W-1:0]        best_suffix,
    output logic [PFX_W-1:0]        best_subarray,
    output logic signed [VAL_W-1:0] largest_element,
    output logic                    range_error
);

    localparam int VB     = VALUE_BITS;
    localparam int SW     = VB + $clog2(SLOTS) + 1;
    localparam int NODES  = 2 * SLOTS;
    localparam int NW     = $clog2(NODES);
    localparam int IW     = NW + 1;
    localparam int NODE_W = 4 * SW + VB;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_UP_RD  = 3'd2;
    localparam logic [2:0] S_UP_WR  = 3'd3;
    localparam logic [2:0] S_Q_STEP = 3'd4;
    localparam logic [2:0] S_Q_L    = 3'd5;
    localparam logic [2:0] S_Q_R    = 3'd6;
    localparam logic [2:0] S_Q_FIN  = 3'd7;

    typedef struct packed {
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] prefix;
        logic signed [SW-1:0] suffix;
        logic signed [SW-1:0] best;
        logic signed [VB-1:0] largest;
    } node_t;

    // control state
    logic [2:0]    state_reg, state_next;
    logic [NW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          left_ok_reg, left_ok_next;
    logic          right_ok_reg, right_ok_next;
    logic          out_valid_reg, out_valid_next;

    // working registers
    logic [NW-1:0] idx_reg, idx_next;
    logic [IW-1:0] l_reg, l_next;
    logic [IW-1:0] r_reg, r_next;
    logic          err_reg, err_next;
    node_t         cur_reg, cur_next;
    node_t         left_reg, left_next;
    node_t         right_reg, right_next;

    // result registers
    logic signed [ANS_W-1:0] ans_reg, ans_next;
    logic signed [ANS_W-1:0] sum_reg, sum_next;
    logic [PFX_W-1:0]        pre_reg, pre_next;
    logic [PFX_W-1:0]        suf_reg, suf_next;
    logic [PFX_W-1:0]        sub_reg, sub_next;
    logic signed [VAL_W-1:0] lrg_reg, lrg_next;
    logic                    rerr_reg, rerr_next;

    // memory and combine unit wiring
    logic              mem_we;
    logic [NW-1:0]     mem_waddr;
    node_t             mem_wdata;
    logic [NW-1:0]     mem_raddr;
    logic [NODE_W-1:0] mem_rdata;
    node_t             rd_node;
    node_t             join_a;
    node_t             join_b;
    logic [NODE_W-1:0] join_res;
    node_t             join_node;

    // decoded input and helpers
    node_t                   leaf_node;
    logic signed [SW-1:0]    leaf_val;
    logic                    in_accept;
    logic                    out_free;
    logic                    bad_range;
    logic [IW-1:0]           r_dec;
    logic [NW-1:0]           parent;
    node_t                   fin_node;
    logic signed [63:0]      ext_sum;
    logic signed [63:0]      ext_best;
    logic signed [63:0]      ext_pre;
    logic signed [63:0]      ext_suf;
    logic signed [63:0]      ext_lrg;

    mss_node_mem #(
        .DEPTH (NODES),
        .AW    (NW),
        .DW    (NODE_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mss_join #(
        .SW (SW),
        .VB (VB)
    ) u_join (
        .a_node   (join_a),
        .b_node   (join_b),
        .res_node (join_res)
    );

    assign rd_node   = node_t'(mem_rdata);
    assign join_node = node_t'(join_res);

    // handshake
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // leaf built from the written value
    assign leaf_val = SW'(slot_value);
    always_comb
    begin
        leaf_node.sum     = leaf_val;
        leaf_node.largest = VB'(slot_value);
        leaf_node.prefix  = leaf_val[SW-1] ? '0 : leaf_val;
        leaf_node.suffix  = leaf_val[SW-1] ? '0 : leaf_val;
        leaf_node.best    = leaf_val[SW-1] ? '0 : leaf_val;
    end

    assign bad_range = (range_first > range_last) || (32'(range_last) >= 32'(SLOTS));
    assign r_dec     = r_reg - IW'(1);
    assign parent    = idx_reg >> 1;

    // final merge of the two accumulators
    always_comb
    begin
        if (!left_ok_reg)
        begin
            fin_node = right_reg;
        end
        else if (!right_ok_reg)
        begin
            fin_node = left_reg;
        end
        else
        begin
            fin_node = join_node;
        end
    end

    assign ext_sum  = 64'(fin_node.sum);
    assign ext_best = 64'(fin_node.best);
    assign ext_pre  = 64'(fin_node.prefix);
    assign ext_suf  = 64'(fin_node.suffix);
    assign ext_lrg  = 64'(fin_node.largest);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        left_ok_next   = left_ok_reg;
        right_ok_next  = right_ok_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        err_next       = err_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        ans_next       = ans_reg;
        sum_next       = sum_reg;
        pre_next       = pre_reg;
        suf_next       = suf_reg;
        sub_next       = sub_reg;
        lrg_next       = lrg_reg;
        rerr_next      = rerr_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_cnt_reg;
        mem_wdata      = '0;
        mem_raddr      = '0;
        join_a         = left_reg;
        join_b         = right_reg;

        // output register drains
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + NW'(1);
                if (clr_cnt_reg == NW'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (func == FUNC_WRITE)
                    begin
                        if (32'(slot_index) < 32'(SLOTS))
                        begin
                            idx_next   = NW'(32'(slot_index) + 32'(SLOTS));
                            mem_we     = 1'b1;
                            mem_waddr  = NW'(32'(slot_index) + 32'(SLOTS));
                            mem_wdata  = leaf_node;
                            cur_next   = leaf_node;
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        err_next      = bad_range;
                        left_ok_next  = 1'b0;
                        right_ok_next = 1'b0;
                        l_next        = IW'(32'(range_first) + 32'(SLOTS));
                        r_next        = IW'(32'(range_last) + 32'(SLOTS) + 32'd1);
                        state_next    = bad_range ? S_Q_FIN : S_Q_STEP;
                    end
                end
            end
            S_UP_RD:
            begin
                mem_raddr  = idx_reg ^ NW'(1);
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                join_a    = idx_reg[0] ? rd_node : cur_reg;
                join_b    = idx_reg[0] ? cur_reg : rd_node;
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = join_node;
                cur_next  = join_node;
                idx_next  = parent;
                state_next = (parent == NW'(1)) ? S_IDLE : S_UP_RD;
            end
            S_Q_STEP:
            begin
                if (l_reg < r_reg)
                begin
                    if (l_reg[0])
                    begin
                        mem_raddr  = l_reg[NW-1:0];
                        state_next = S_Q_L;
                    end
                    else if (r_reg[0])
                    begin
                        mem_raddr  = r_dec[NW-1:0];
                        state_next = S_Q_R;
                    end
                    else
                    begin
                        l_next = l_reg >> 1;
                        r_next = r_reg >> 1;
                    end
                end
                else
                begin
                    state_next = S_Q_FIN;
                end
            end
            S_Q_L:
            begin
                join_a       = left_reg;
                join_b       = rd_node;
                left_next    = left_ok_reg ? join_node : rd_node;
                left_ok_next = 1'b1;
                if (r_reg[0])
                begin
                    l_next     = l_reg + IW'(1);
                    mem_raddr  = r_dec[NW-1:0];
                    state_next = S_Q_R;
                end
                else
                begin
                    l_next     = (l_reg + IW'(1)) >> 1;
                    r_next     = r_reg >> 1;
                    state_next = S_Q_STEP;
                end
            end
            S_Q_R:
            begin
                join_a        = rd_node;
                join_b        = right_reg;
                right_next    = right_ok_reg ? join_node : rd_node;
                right_ok_next = 1'b1;
                l_next        = l_reg >> 1;
                r_next        = r_dec >> 1;
                state_next    = S_Q_STEP;
            end
            S_Q_FIN:
            begin
                join_a = left_reg;
                join_b = right_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (err_reg)
                    begin
                        ans_next  = '0;
                        sum_next  = '0;
                        pre_next  = '0;
                        suf_next  = '0;
                        sub_next  = '0;
                        lrg_next  = '0;
                        rerr_next = 1'b1;
                    end
                    else
                    begin
                        ans_next  = fin_node.largest[VB-1] ? ext_lrg[ANS_W-1:0]
                                                            : ext_best[ANS_W-1:0];
                        sum_next  = ext_sum[ANS_W-1:0];
                        pre_next  = ext_pre[PFX_W-1:0];
                        suf_next  = ext_suf[PFX_W-1:0];
                        sub_next  = ext_best[PFX_W-1:0];
                        lrg_next  = ext_lrg[VAL_W-1:0];
                        rerr_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            left_ok_reg   <= 1'b0;
            right_ok_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            left_ok_reg   <= left_ok_next;
            right_ok_reg  <= right_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        err_reg   <= err_next;
        cur_reg   <= cur_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        ans_reg   <= ans_next;
        sum_reg   <= sum_next;
        pre_reg   <= pre_next;
        suf_reg   <= suf_next;
        sub_reg   <= sub_next;
        lrg_reg   <= lrg_next;
        rerr_reg  <= rerr_next;
    end

    assign out_valid       = out_valid_reg;
    assign best_answer     = ans_reg;
    assign range_sum       = sum_reg;
    assign best_prefix     = pre_reg;
    assign best_suffix     = suf_reg;
    assign best_subarray   = sub_reg;
    assign largest_element = lrg_reg;
    assign range_error     = rerr_reg;

endmodule

@@ rtl/mss_join.sv @@
// combine unit: merges a left node and a right node into their parent figures
module mss_join
    import mss_pkg::*;
#(
    parameter int SW = VALUE_BITS + 11,
    parameter int VB = VALUE_BITS,
    localparam int NODE_W = 4 * SW + VB
)
(
    input  logic [NODE_W-1:0] a_node,
    input  logic [NODE_W-1:0] b_node,
    output logic [NODE_W-1:0] res_node
);

    typedef struct packed {
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] prefix;
        logic signed [SW-1:0] suffix;
        logic signed [SW-1:0] best;
        logic signed [VB-1:0] largest;
    } node_t;

    node_t a;
    node_t b;
    node_t r;
    logic signed [SW-1:0] pre_alt;
    logic signed [SW-1:0] suf_alt;
    logic signed [SW-1:0] mid;
    logic signed [SW-1:0] side_best;

    assign a = node_t'(a_node);
    assign b = node_t'(b_node);

    // crossing sums
    assign pre_alt = a.sum + b.prefix;
    assign suf_alt = b.sum + a.suffix;
    assign mid     = a.suffix + b.prefix;
    assign side_best = (a.best > b.best) ? a.best : b.best;

    // parent figures
    always_comb
    begin
        r.sum     = a.sum + b.sum;
        r.prefix  = (pre_alt > a.prefix) ? pre_alt : a.prefix;
        r.suffix  = (suf_alt > b.suffix) ? suf_alt : b.suffix;
        r.best    = (mid > side_best) ? mid : side_best;
        r.largest = (a.largest > b.largest) ? a.largest : b.largest;
    end

    assign res_node = r;

endmodule

@@ rtl/mss_node_mem.sv @@
// single-port-write, registered-read node store
module mss_node_mem
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 204
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mss_checker.sv @@
// port-level checker for the maximum-subarray segment tree, bound to the top level
`include "max_subarray_segment_tree_macros.svh"

module mss_checker
    import mss_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [ANS_W-1:0] best_answer,
    input logic signed [ANS_W-1:0] range_sum,
    input logic [PFX_W-1:0]        best_prefix,
    input logic [PFX_W-1:0]        best_suffix,
    input logic [PFX_W-1:0]        best_subarray,
    input logic signed [VAL_W-1:0] largest_element,
    input logic                    range_error
);

    logic signed [ANS_W-1:0] largest_ext;
    logic                    err_fields_zero;
    logic                    best_covers_ends;

    // helper terms for the properties
    assign largest_ext      = ANS_W'(largest_element);
    assign err_fields_zero  = (best_answer == '0) && (range_sum == '0) && (best_prefix == '0)
                              && (best_suffix == '0) && (best_subarray == '0)
                              && (largest_element == '0);
    assign best_covers_ends = (best_subarray >= best_prefix) && (best_subarray >= best_suffix);

    // a held result stays offered
    `MSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // a rejected range carries only zeros
    `MSS_ASSERT_NOW(a_err_zero, out_valid && range_error, err_fields_zero)

    // the best subarray covers the best prefix and suffix
    `MSS_ASSERT_NOW(a_best_dom, out_valid && !range_error, best_covers_ends)

    // answer rule picks the negative largest element
    `MSS_ASSERT_NOW(a_answer_neg, out_valid && !range_error && largest_element[VAL_W-1], best_answer == largest_ext)

endmodule

bind max_subarray_segment_tree mss_checker u_mss_checker (.*);

@@ verif/max_subarray_segment_tree_tb.sv @@
// self-checking testbench for the maximum-subarray segment tree
`timescale 1ns / 100ps

module max_subarray_segment_tree_tb
    import mss_pkg::*;
();

    localparam int NSLOT = SLOTS_DEFAULT;
    localparam int NNODE = 2 * NSLOT;
    localparam longint CYCLE_LIMIT = 4000000;

    // one query outcome
    typedef struct packed {
        logic signed [ANS_W-1:0] answer;
        logic signed [ANS_W-1:0] sum;
        logic [PFX_W-1:0]        prefix;
        logic [PFX_W-1:0]        suffix;
        logic [PFX_W-1:0]        best;
        logic signed [VAL_W-1:0] largest;
        logic                    err;
    } query_res_t;

    // figures for one covered span
    typedef struct {
        longint sum;
        longint prefix;
        longint suffix;
        longint best;
        longint largest;
    } span_t;

    // tree mirror and queue of expected query outcomes
    class range_query_scoreboard;
        span_t tree[NNODE];
        query_res_t pending[$];
        int errors;

        function new();
            span_t z;
            z = '{0, 0, 0, 0, 0};
            foreach (tree[i]) tree[i] = z;
            errors = 0;
        endfunction

        function longint max2(longint a, longint b);
            return a > b ? a : b;
        endfunction

        function span_t merge(span_t a, span_t b);
            span_t s;
            s.sum = a.sum + b.sum;
            s.prefix = max2(a.prefix, a.sum + b.prefix);
            s.suffix = max2(b.suffix, b.sum + a.suffix);
            s.best = max2(max2(a.best, b.best), a.suffix + b.prefix);
            s.largest = max2(a.largest, b.largest);
            return s;
        endfunction

        // note one accepted transaction
        function void note_input(logic f, logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] v,
                                 logic [IDX_W-1:0] first, logic [IDX_W-1:0] last);
            int i, l, r;
            longint val;
            span_t lt, rt, res;
            query_res_t q;
            if (f == FUNC_WRITE) begin
                val = v;
                i = NSLOT + idx;
                tree[i].sum = val;
                tree[i].largest = val;
                tree[i].prefix = max2(0, val);
                tree[i].suffix = max2(0, val);
                tree[i].best = max2(0, val);
                for (i = i >> 1; i >= 1; i = i >> 1)
                    tree[i] = merge(tree[2*i], tree[2*i+1]);
                return;
            end
            q = '0;
            if (first > last || last >= NSLOT) begin
                q.err = 1'b1;
            end else begin
                l = NSLOT + first;
                r = NSLOT + last + 1;
                lt = '{0, 0, 0, 0, 64'sh8000000000000000};
                rt = lt;
                while (l < r) begin
                    if (l & 1) begin
                        lt = merge(lt, tree[l]);
                        l++;
                    end
                    if (r & 1) begin
                        r--;
                        rt = merge(tree[r], rt);
                    end
                    l = l >> 1;
                    r = r >> 1;
                end
                res = merge(lt, rt);
                q.answer = ANS_W'(res.largest < 0 ? res.largest : res.best);
                q.sum = ANS_W'(res.sum);
                q.prefix = PFX_W'(res.prefix);
                q.suffix = PFX_W'(res.suffix);
                q.best = PFX_W'(res.best);
                q.largest = VAL_W'(res.largest);
            end
            pending.insert(pending.size(), q);
        endfunction

        // compare one result with the oldest expectation
        function void check_result(query_res_t got);
            query_res_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.answer !== e.answer) begin
                $display("%0t best_answer exp %0d got %0d", $time, e.answer, got.answer);
                errors++;
            end
            if (got.sum !== e.sum) begin
                $display("%0t range_sum exp %0d got %0d", $time, e.sum, got.sum);
                errors++;
            end
            if (got.prefix !== e.prefix) begin
                $display("%0t best_prefix exp %0d got %0d", $time, e.prefix, got.prefix);
                errors++;
            end
            if (got.suffix !== e.suffix) begin
                $display("%0t best_suffix exp %0d got %0d", $time, e.suffix, got.suffix);
                errors++;
            end
            if (got.best !== e.best) begin
                $display("%0t best_subarray exp %0d got %0d", $time, e.best, got.best);
                errors++;
            end
            if (got.largest !== e.largest) begin
                $display("%0t largest_element exp %0d got %0d", $time, e.largest,
                         got.largest);
                errors++;
            end
            if (got.err !== e.err) begin
                $display("%0t range_error exp %0b got %0b", $time, e.err, got.err);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic func;
    logic [IDX_W-1:0] slot_index;
    logic signed [VAL_W-1:0] slot_value;
    logic [IDX_W-1:0] range_first;
    logic [IDX_W-1:0] range_last;
    logic out_valid;
    logic out_stall;
    logic signed [ANS_W-1:0] best_answer;
    logic signed [ANS_W-1:0] range_sum;
    logic [PFX_W-1:0] best_prefix;
    logic [PFX_W-1:0] best_suffix;
    logic [PFX_W-1:0] best_subarray;
    logic signed [VAL_W-1:0] largest_element;
    logic range_error;

    range_query_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    longint cycles = 0;

    max_subarray_segment_tree dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .func(func),
        .slot_index(slot_index), .slot_value(slot_value), .range_first(range_first),
        .range_last(range_last), .out_valid(out_valid), .out_stall(out_stall),
        .best_answer(best_answer), .range_sum(range_sum), .best_prefix(best_prefix),
        .best_suffix(best_suffix), .best_subarray(best_subarray),
        .largest_element(largest_element), .range_error(range_error)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL max_subarray_segment_tree");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({best_answer, range_sum, best_prefix, best_suffix, best_subarray,
                             largest_element, range_error});
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // send one transaction, with random leading idle
    task automatic send_item(logic f, logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] v,
                             logic [IDX_W-1:0] first, logic [IDX_W-1:0] last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        slot_index <= idx;
        slot_value <= v;
        range_first <= first;
        range_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(f, idx, v, first, last);
        @(negedge clk);
    endtask

    task automatic send_write(int idx, logic signed [VAL_W-1:0] v);
        send_item(FUNC_WRITE, IDX_W'(idx), v, IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic send_query(int first, int last);
        send_item(FUNC_QUERY, IDX_W'($urandom), $urandom, IDX_W'(first), IDX_W'(last));
    endtask

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(3);
            2: return 32'sh80000000 + $urandom_range(3);
            default: return $signed($urandom_range(2000)) - 1000;
        endcase
    endfunction

    // random mix: mostly writes and valid queries in a small window
    task automatic random_phase(int n);
        int a, b, base;
        repeat (n) begin
            base = ($urandom_range(3) == 0) ? 0 : $urandom_range(NSLOT - 32);
            a = base + $urandom_range(31);
            b = a + $urandom_range(31);
            if (b >= NSLOT) b = NSLOT - 1;
            case ($urandom_range(9))
                0, 1, 2, 3: send_write($urandom_range(NSLOT - 1), rand_value());
                4: send_write(base + $urandom_range(31), rand_value());
                5: send_query($urandom_range(NSLOT - 1), $urandom_range(NSLOT - 1));
                6: send_query(b, a);
                default: send_query(a, b);
            endcase
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        func = FUNC_WRITE;
        slot_index = '0;
        slot_value = '0;
        range_first = '0;
        range_last = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed: untouched tree, extremes, empty (reversed) ranges
        send_query(0, NSLOT - 1);
        send_write(0, 32'sh7fffffff);
        send_write(NSLOT - 1, 32'sh7fffffff);
        send_write(1, 32'sh80000000);
        send_write(2, -5);
        send_write(3, 7);
        send_query(0, NSLOT - 1);
        send_query(0, 0);
        send_query(1, 1);
        send_query(1, 2);
        send_query(NSLOT - 1, NSLOT - 1);
        send_query(5, 4);
        send_query(NSLOT - 1, 0);
        send_write(10, -1);
        send_write(11, -3);
        send_query(10, 11);
        send_query(2, 3);
        send_write(0, 32'sh80000000);
        send_write(NSLOT - 1, 32'sh80000000);
        send_query(0, NSLOT - 1);
        send_query(0, 3);
        drain();

        // random phases with mixes of sender idle and receiver stall
        random_phase(500);
        send_idle_pct = 59;
        random_phase(400);
        send_idle_pct = 0;
        recv_stall_pct = 59;
        random_phase(400);
        send_idle_pct = 6;
        recv_stall_pct = 6;
        random_phase(300);

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
            random_phase(60);
        join
        // sender pause until all results are in
        drain();
        random_phase(340);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS max_subarray_segment_tree");
        else
            $display("FAIL max_subarray_segment_tree");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/mss_pkg.sv
rtl/mss_join.sv
rtl/mss_node_mem.sv
rtl/max_subarray_segment_tree.sv
rtl/mss_checker.sv
verif/max_subarray_segment_tree_tb.sv
